### rtl/kmd_pkg.sv
// kmd_pkg: shared types, constants and register codes of the key matrix debouncer
// used by every module of the block; depends on nothing

package kmd_pkg;

   // sizes
   localparam int NUM_KEYS  = 128;
   localparam int KEY_AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int TIME_BITS = 48;
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);

   localparam logic [7:0] COUNT_MAX = 8'd255;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   // register indexes (byte address divided by four)
   localparam logic [2:0] REG_MODE_TIME       = 3'd0;
   localparam logic [2:0] REG_COUNT_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_PRESS_TIME      = 3'd2;
   localparam logic [2:0] REG_RELEASE_TIME    = 3'd3;
   localparam logic [2:0] REG_REPRESS_GUARD   = 3'd4;

   // reset values of the threshold, press time and release time registers
   localparam logic [7:0]  THRESHOLD_RST = 8'd5;
   localparam logic [23:0] PRESS_RST     = 24'd5000;
   localparam logic [23:0] RELEASE_RST   = 24'd5000;

   typedef struct packed {
      logic [6:0]           key_index;
      logic                 raw_level;
      logic [TIME_BITS-1:0] timestamp;
   } req_item_type;

   typedef struct packed {
      logic [6:0] key_out;
      logic [1:0] event_code;
   } rsp_item_type;

   // item as classified by the front end
   typedef struct packed {
      req_item_type item;
      logic         in_range;
   } entry_type;

   typedef struct packed {
      logic        mode_time;
      logic [7:0]  count_threshold;
      logic [23:0] press_time;
      logic [23:0] release_time;
      logic [23:0] repress_guard;
   } cfg_type;

   // per-key state word
   typedef struct packed {
      logic                 last_raw;
      logic                 stable_level;
      logic [7:0]           sample_count;
      logic [TIME_BITS-1:0] raw_change_time;
      logic [TIME_BITS-1:0] release_seen;
   } key_state_type;

endpackage

### rtl/kmd_front.sv
// kmd_front: input register of the debouncer, accepts sample transfers and
// tags each with a key range check; depends on kmd_pkg

module kmd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kmd_pkg::req_item_type req_item,
   input  logic                  q_full,
   output logic                  push,
   output kmd_pkg::entry_type    push_data
);
   import kmd_pkg::*;

   logic      front_valid_ff, front_valid_in;
   entry_type front_ff;
   logic      accept;

   // stall only while the held item cannot move into the queue
   assign req_stall = front_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !q_full;
   assign push_data = front_ff;

   always_comb begin
      front_valid_in = accept || (front_valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   // payload with key classification
   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff.item     <= req_item;
         front_ff.in_range <= (32'(req_item.key_index) < 32'(NUM_KEYS));
      end
   end

endmodule

### rtl/kmd_queue.sv
// kmd_queue: short fifo between the front end and the state update engine
// depends on kmd_pkg

module kmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kmd_pkg::entry_type push_data,
   output logic               full,
   output logic               head_valid,
   output kmd_pkg::entry_type head_data,
   input  logic               pop
);
   import kmd_pkg::*;

   entry_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;

   assign full       = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/kmd_back.sv
// kmd_back: per-key state memory and debounce update, with result register
// depends on kmd_pkg

module kmd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  kmd_pkg::cfg_type      cfg,
   input  logic                  head_valid,
   input  kmd_pkg::entry_type    head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kmd_pkg::rsp_item_type rsp_item
);
   import kmd_pkg::*;

   // state memory and per-entry written flags
   key_state_type        state_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]  vld_ff;

   // update stage
   logic                 s2_valid_ff, s2_valid_in;
   entry_type            s2_ff;
   key_state_type        rd_data_ff;
   logic                 rd_vld_ff;
   logic                 byp_ff;
   key_state_type        byp_data_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   rsp_item_type         out_item_ff;

   logic                 s2_adv, s2_load;
   logic [KEY_AW-1:0]    rd_addr, wr_addr;
   logic                 wr_en;
   key_state_type        cur, nxt;
   logic [1:0]           ev;

   logic                 lvl, same;
   logic [TIME_BITS-1:0] now;
   logic [7:0]           cnt_inc, thr;
   logic [23:0]          hold;
   logic [TIME_BITS-1:0] elapsed, since_rel;
   logic                 guard_hit, fire;

   // pipeline handshake
   assign s2_adv    = s2_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s2_load   = head_valid && (!s2_valid_ff || s2_adv);
   assign pop       = s2_load;
   assign rd_addr   = head_data.item.key_index[KEY_AW-1:0];
   assign wr_addr   = s2_ff.item.key_index[KEY_AW-1:0];
   assign wr_en     = s2_adv && s2_ff.in_range;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // current state: forwarded write, stored word, or the cleared value
   always_comb begin
      if (byp_ff) begin
         cur = byp_data_ff;
      end else if (rd_vld_ff) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end
   end

   // debounce update of one key
   always_comb begin
      lvl       = s2_ff.item.raw_level;
      now       = s2_ff.item.timestamp;
      same      = (lvl == cur.last_raw);
      cnt_inc   = (cur.sample_count == COUNT_MAX) ? COUNT_MAX : cur.sample_count + 8'd1;
      thr       = (cfg.count_threshold == 8'd0) ? 8'd1 : cfg.count_threshold;
      elapsed   = now - cur.raw_change_time;
      since_rel = cur.raw_change_time - cur.release_seen;
      guard_hit = lvl && (cur.release_seen != '0)
                  && (cur.raw_change_time >= cur.release_seen)
                  && (since_rel <= TIME_BITS'(cfg.repress_guard))
                  && (cfg.release_time > cfg.press_time);
      hold      = lvl ? (guard_hit ? cfg.release_time : cfg.press_time) : cfg.release_time;
      nxt       = cur;
      nxt.last_raw     = lvl;
      nxt.sample_count = same ? cnt_inc : 8'd1;
      fire      = 1'b0;
      if (cfg.mode_time) begin
         if (!same) begin
            nxt.raw_change_time = now;
         end else begin
            fire = (now >= cur.raw_change_time)
                   && (elapsed >= TIME_BITS'(hold))
                   && (lvl != cur.stable_level);
         end
      end else begin
         fire = (nxt.sample_count >= thr) && (lvl != cur.stable_level);
      end
      if (!s2_ff.in_range) begin
         fire = 1'b0;
      end
      ev = EV_NONE;
      if (fire) begin
         ev = lvl ? EV_PRESS : EV_RELEASE;
         nxt.stable_level = lvl;
         if (!lvl && cfg.mode_time && (now != '0)) begin
            nxt.release_seen = now;
         end
      end
   end

   always_comb begin
      s2_valid_in  = s2_load || (s2_valid_ff && !s2_adv);
      out_valid_in = s2_adv || (out_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // state memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= nxt;
      end
      if (s2_load) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

   // stage payload, forwarding of a same-key write in the same cycle
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_ff       <= head_data;
         rd_vld_ff   <= vld_ff[rd_addr] || (wr_en && (wr_addr == rd_addr));
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= nxt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_item_ff.key_out    <= s2_ff.item.key_index;
         out_item_ff.event_code <= ev;
      end
   end

   // a key outside the matrix never yields an event
   a_range_no_event: assert property (@(posedge clock) disable iff (reset)
      (s2_adv && !s2_ff.in_range) |=> (out_item_ff.event_code == EV_NONE))
      else $error("event reported for key outside the matrix");

   // a raw level change in time mode only restarts the hold time
   a_change_no_event: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && cfg.mode_time && !same) |-> (ev == EV_NONE))
      else $error("event on raw level change in time mode");

   // an event always moves the stable level to the sampled level
   a_event_commits: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (ev != EV_NONE)) |-> (nxt.stable_level == lvl && cur.stable_level != lvl))
      else $error("event without stable level change");

endmodule

### rtl/key_matrix_debouncer_core.sv
// key_matrix_debouncer_core: top level with register file, front end, queue
// and state update engine; depends on kmd_pkg, kmd_front, kmd_queue, kmd_back
// path: front register, queue slot, update stage and result register, in order
// throughput: one sample per cycle without rsp_stall, set by the state memory's
// separate read and write ports with same-key forwarding in the update stage
// reset: synchronous; registers take their reset values and all key state
// reads as zero at once (written flags cleared), no clearing pass

module key_matrix_debouncer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kmd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kmd_pkg::rsp_item_type rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import kmd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       cfg_wr;
   logic [2:0] reg_idx;

   logic       push, q_full, head_valid, pop;
   entry_type  push_data, head_data;

   // register file
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_idx)
            REG_MODE_TIME:       cfg_in.mode_time       = csr_pwdata[0];
            REG_COUNT_THRESHOLD: cfg_in.count_threshold = csr_pwdata[7:0];
            REG_PRESS_TIME:      cfg_in.press_time      = csr_pwdata[23:0];
            REG_RELEASE_TIME:    cfg_in.release_time    = csr_pwdata[23:0];
            REG_REPRESS_GUARD:   cfg_in.repress_guard   = csr_pwdata[23:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE_TIME:       csr_prdata = {31'd0, cfg_ff.mode_time};
         REG_COUNT_THRESHOLD: csr_prdata = {24'd0, cfg_ff.count_threshold};
         REG_PRESS_TIME:      csr_prdata = {8'd0, cfg_ff.press_time};
         REG_RELEASE_TIME:    csr_prdata = {8'd0, cfg_ff.release_time};
         REG_REPRESS_GUARD:   csr_prdata = {8'd0, cfg_ff.repress_guard};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_time       <= 1'b0;
         cfg_ff.count_threshold <= THRESHOLD_RST;
         cfg_ff.press_time      <= PRESS_RST;
         cfg_ff.release_time    <= RELEASE_RST;
         cfg_ff.repress_guard   <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   kmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   kmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // state update engine
   kmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
